/* hw/rtl/cbsd_pkg.sv */
package cbsd_pkg;

  localparam int NUM_MODULES_DEF      = 8;
  localparam int CELLS_PER_MODULE_DEF = 12;
  localparam int CELLS_PER_ROW        = 3;
  localparam int CELL_W               = 12;
  localparam int ROW_DATA_W           = CELLS_PER_ROW * CELL_W;

  // frame ids that carry data
  localparam logic [10:0] ID_PRECHARGE = 11'h08A;
  localparam logic [10:0] ID_FUSE      = 11'h090;
  localparam logic [10:0] ID_HEALTH    = 11'h098;
  localparam logic [10:0] ID_PACK_V    = 11'h0CA;
  localparam logic [10:0] ID_TEMP      = 11'h148;
  localparam logic [10:0] ID_CELL_MM   = 11'h14C;
  localparam logic [10:0] ID_SOC       = 11'h207;
  localparam logic [10:0] ID_CELL_V    = 11'h27A;

  // frame ids that only mark the battery alive
  localparam logic [10:0] ID_ALIVE_0  = 11'h088;
  localparam logic [10:0] ID_ALIVE_1  = 11'h08C;
  localparam logic [10:0] ID_ALIVE_2  = 11'h08E;
  localparam logic [10:0] ID_ALIVE_3  = 11'h0C8;
  localparam logic [10:0] ID_ALIVE_4  = 11'h0EA;
  localparam logic [10:0] ID_ALIVE_5  = 11'h146;
  localparam logic [10:0] ID_ALIVE_6  = 11'h14E;
  localparam logic [10:0] ID_ALIVE_7  = 11'h171;
  localparam logic [10:0] ID_ALIVE_8  = 11'h204;
  localparam logic [10:0] ID_ALIVE_9  = 11'h27E;
  localparam logic [10:0] ID_ALIVE_10 = 11'h310;
  localparam logic [10:0] ID_ALIVE_11 = 11'h318;

  localparam logic [7:0] TEMP_OFFSET   = 8'd40;
  localparam logic [1:0] CRIT_RUNAWAY  = 2'd2;

  // status bit positions
  localparam int ST_PRECHARGE = 0;
  localparam int ST_CONTACTOR = 1;
  localparam int ST_INTERLOCK = 2;
  localparam int ST_FUSE_AUX  = 3;
  localparam int ST_FUSE_FRNT = 4;
  localparam int ST_FUSE_REAR = 5;

  typedef logic [7:0]        data_byte_t;
  typedef data_byte_t [7:0]  frame_data_t;

  typedef struct packed {
    logic [13:0]        soc;
    logic [9:0]         health;
    logic [9:0]         pack_v;
    logic [12:0]        cell_low;
    logic [12:0]        cell_high;
    logic signed [7:0]  temp_hot;
    logic signed [7:0]  temp_cold;
    logic [5:0]         bits;
    logic               runaway;
  } status_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] lane;
  } cell_sel_t;

endpackage

/* hw/rtl/cbsd_ram.sv */
module cbsd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/cbsd_cell_map.sv */
module cbsd_cell_map #(
  parameter int NUM_MODULES      = cbsd_pkg::NUM_MODULES_DEF,
  parameter int CELLS_PER_MODULE = cbsd_pkg::CELLS_PER_MODULE_DEF,
  localparam int GROUPS     = CELLS_PER_MODULE / cbsd_pkg::CELLS_PER_ROW,
  localparam int ROWS       = NUM_MODULES * GROUPS,
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int STORE_SIZE = NUM_MODULES * CELLS_PER_MODULE
) (
  input  logic                              cmd,
  input  logic [10:0]                       frame_id,
  input  cbsd_pkg::frame_data_t             data,
  input  logic [6:0]                        cell_index,
  output logic                              wr_en,
  output logic [ROW_W-1:0]                  wr_row,
  output logic [cbsd_pkg::ROW_DATA_W-1:0]   wr_data,
  output logic [ROW_W-1:0]                  rd_row,
  output cbsd_pkg::cell_sel_t               rd_sel
);

  logic [6:0]  mod_num;
  logic [5:0]  grp_num;
  logic [10:0] wr_row_full;
  logic [4:0]  rd_mod;
  logic [9:0]  rd_mod_ofs;
  logic [4:0]  rd_cell;
  logic [13:0] rd_prod;
  logic [3:0]  rd_grp;
  logic [4:0]  rd_lane_full;
  logic [10:0] rd_row_full;

  // write side: module and group come from the first two bytes
  assign mod_num = data[0][7:1];
  assign grp_num = data[1][7:2];

  assign wr_en = !cmd && (frame_id == cbsd_pkg::ID_CELL_V) &&
                 (mod_num >= 7'd1) && (mod_num <= 7'(NUM_MODULES)) &&
                 (grp_num >= 6'd1) && (grp_num <= 6'(GROUPS));

  assign wr_row_full = 11'(mod_num - 7'd1) * 11'(GROUPS) + 11'(grp_num - 6'd1);
  assign wr_row      = wr_row_full[ROW_W-1:0];
  assign wr_data     = {data[6][3:0], data[7], data[4][3:0], data[5],
                        data[2][3:0], data[3]};

  // read side: split the flat index into module, group and lane
  always_comb begin
    rd_mod = '0;
    for (int k = 1; k < NUM_MODULES; k++) begin
      if ({3'b000, cell_index} >= 10'(k * CELLS_PER_MODULE)) begin
        rd_mod = 5'(k);
      end
    end
  end

  assign rd_mod_ofs   = 10'(rd_mod * CELLS_PER_MODULE);
  assign rd_cell      = 5'({3'b000, cell_index} - rd_mod_ofs);
  // divide by three through the reciprocal, exact for the cell range
  assign rd_prod      = 14'(rd_cell) * 14'd171;
  assign rd_grp       = rd_prod[12:9];
  assign rd_lane_full = rd_cell - {rd_grp, 1'b0} - {1'b0, rd_grp};
  assign rd_row_full  = 11'(rd_mod) * 11'(GROUPS) + 11'(rd_grp);
  assign rd_row       = rd_row_full[ROW_W-1:0];

  assign rd_sel.hit  = ({3'b000, cell_index} < 10'(STORE_SIZE)) &&
                       (5'(rd_grp) < 5'(GROUPS));
  assign rd_sel.lane = rd_lane_full[1:0];

endmodule

/* hw/rtl/cbsd_status.sv */
module cbsd_status (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  is_frame,
  input  logic [10:0]           frame_id,
  input  cbsd_pkg::frame_data_t data,
  output cbsd_pkg::status_t     st_next,
  output logic                  known
);

  cbsd_pkg::status_t st;

  always_comb begin
    st_next = st;
    known   = 1'b0;
    if (is_frame) begin
      known = 1'b1;
      case (frame_id)
        cbsd_pkg::ID_PRECHARGE: begin
          st_next.bits[cbsd_pkg::ST_PRECHARGE] = data[6][4];
        end
        cbsd_pkg::ID_FUSE: begin
          st_next.bits[cbsd_pkg::ST_FUSE_FRNT] = data[2][6];
          st_next.bits[cbsd_pkg::ST_FUSE_REAR] = data[2][7];
        end
        cbsd_pkg::ID_HEALTH: begin
          st_next.bits[cbsd_pkg::ST_CONTACTOR] = data[1][6];
          st_next.bits[cbsd_pkg::ST_INTERLOCK] = data[1][7];
          st_next.bits[cbsd_pkg::ST_FUSE_AUX]  = data[3][7];
          st_next.health = {data[4][1:0], data[5]};
          if (data[5][3:2] == cbsd_pkg::CRIT_RUNAWAY) begin
            st_next.runaway = 1'b1;
          end
        end
        cbsd_pkg::ID_PACK_V: begin
          st_next.pack_v = {data[3][1:0], data[4]};
        end
        cbsd_pkg::ID_TEMP: begin
          st_next.temp_hot  = {1'b0, data[5][7:1]} - cbsd_pkg::TEMP_OFFSET;
          st_next.temp_cold = {1'b0, data[6][7:1]} - cbsd_pkg::TEMP_OFFSET;
        end
        cbsd_pkg::ID_CELL_MM: begin
          st_next.cell_low  = {data[4][4:0], data[5]};
          st_next.cell_high = {data[6][4:0], data[7]};
        end
        cbsd_pkg::ID_SOC: begin
          st_next.soc = {data[6][5:0], data[7]};
        end
        cbsd_pkg::ID_CELL_V: begin
          // cell store is written on the way in
          known = 1'b1;
        end
        default: begin
          known = frame_id inside {
            cbsd_pkg::ID_ALIVE_0, cbsd_pkg::ID_ALIVE_1, cbsd_pkg::ID_ALIVE_2,
            cbsd_pkg::ID_ALIVE_3, cbsd_pkg::ID_ALIVE_4, cbsd_pkg::ID_ALIVE_5,
            cbsd_pkg::ID_ALIVE_6, cbsd_pkg::ID_ALIVE_7, cbsd_pkg::ID_ALIVE_8,
            cbsd_pkg::ID_ALIVE_9, cbsd_pkg::ID_ALIVE_10, cbsd_pkg::ID_ALIVE_11};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

endmodule

/* hw/rtl/can_battery_status_decoder_core.sv */
// Decodes received battery CAN frames into status values and serves reads of
// stored cell voltages. One word is accepted per clock while in_stall is low;
// each word gives one result through the input stage, with the cell store
// read, and then the result register; an output register lets a new word in
// while a result waits. The cell store is a single memory of
// NUM_MODULES*(CELLS_PER_MODULE/3) rows of three cells, one write and one read
// port; id 0x27A frames write a row as they are accepted. After reset a
// clearing pass zeroes one row per cycle over all the rows (32 at the
// defaults), with in_stall held high until it is done.
module can_battery_status_decoder_core #(
  parameter int NUM_MODULES      = cbsd_pkg::NUM_MODULES_DEF,
  parameter int CELLS_PER_MODULE = cbsd_pkg::CELLS_PER_MODULE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [10:0]        frame_id,
  input  logic [7:0]         byte0,
  input  logic [7:0]         byte1,
  input  logic [7:0]         byte2,
  input  logic [7:0]         byte3,
  input  logic [7:0]         byte4,
  input  logic [7:0]         byte5,
  input  logic [7:0]         byte6,
  input  logic [7:0]         byte7,
  input  logic [6:0]         cell_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        soc_raw,
  output logic [13:0]        soh_scaled,
  output logic [13:0]        pack_voltage_dv,
  output logic [12:0]        cell_max_mv,
  output logic [12:0]        cell_min_mv,
  output logic signed [10:0] temp_max_dc,
  output logic signed [10:0] temp_min_dc,
  output logic [4:0]         flags,
  output logic [11:0]        cell_voltage_mv,
  output logic               frame_known
);

  localparam int GROUPS = CELLS_PER_MODULE / cbsd_pkg::CELLS_PER_ROW;
  localparam int ROWS   = NUM_MODULES * GROUPS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DATA_W = cbsd_pkg::ROW_DATA_W;
  localparam int CW     = cbsd_pkg::CELL_W;

  cbsd_pkg::frame_data_t in_data;
  logic                  accept;
  logic                  adv;

  // clearing pass
  logic             clearing;
  logic [ROW_W-1:0] clr_row;

  // cell store ports
  logic              map_wr_en;
  logic [ROW_W-1:0]  map_wr_row;
  logic [DATA_W-1:0] map_wr_data;
  logic [ROW_W-1:0]  map_rd_row;
  cbsd_pkg::cell_sel_t map_rd_sel;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  // input stage
  logic                  s1_valid;
  logic                  s1_cmd;
  logic [10:0]           s1_id;
  cbsd_pkg::frame_data_t s1_data;
  cbsd_pkg::cell_sel_t   s1_sel;

  cbsd_pkg::status_t st_next;
  logic              known;
  logic [CW-1:0]     cell_sel_val;
  logic [10:0]       hot_ext;
  logic [10:0]       cold_ext;

  assign in_data = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};

  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clearing || (s1_valid && !adv);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  cbsd_cell_map #(
    .NUM_MODULES      (NUM_MODULES),
    .CELLS_PER_MODULE (CELLS_PER_MODULE)
  ) u_cell_map (
    .cmd        (cmd),
    .frame_id   (frame_id),
    .data       (in_data),
    .cell_index (cell_index),
    .wr_en      (map_wr_en),
    .wr_row     (map_wr_row),
    .wr_data    (map_wr_data),
    .rd_row     (map_rd_row),
    .rd_sel     (map_rd_sel)
  );

  assign ram_we    = clearing || (accept && map_wr_en);
  assign ram_waddr = clearing ? clr_row : map_wr_row;
  assign ram_wdata = clearing ? '0 : map_wr_data;

  cbsd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROWS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (map_rd_row),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= cmd;
      s1_id   <= frame_id;
      s1_data <= in_data;
      s1_sel  <= map_rd_sel;
    end
  end

  cbsd_status u_status (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .is_frame (!s1_cmd),
    .frame_id (s1_id),
    .data     (s1_data),
    .st_next  (st_next),
    .known    (known)
  );

  always_comb begin
    case (s1_sel.lane)
      2'd0:    cell_sel_val = ram_rdata[CW-1:0];
      2'd1:    cell_sel_val = ram_rdata[2*CW-1:CW];
      2'd2:    cell_sel_val = ram_rdata[3*CW-1:2*CW];
      default: cell_sel_val = '0;
    endcase
  end

  assign hot_ext  = {{3{st_next.temp_hot[7]}}, st_next.temp_hot};
  assign cold_ext = {{3{st_next.temp_cold[7]}}, st_next.temp_cold};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // times ten as shift and add
  always_ff @(posedge clk) begin
    if (adv) begin
      soc_raw         <= st_next.soc;
      soh_scaled      <= {1'b0, st_next.health, 3'b000} + {3'b000, st_next.health, 1'b0};
      pack_voltage_dv <= {1'b0, st_next.pack_v, 3'b000} + {3'b000, st_next.pack_v, 1'b0};
      cell_max_mv     <= st_next.cell_high;
      cell_min_mv     <= st_next.cell_low;
      temp_max_dc     <= signed'({hot_ext[7:0], 3'b000} + {hot_ext[9:0], 1'b0});
      temp_min_dc     <= signed'({cold_ext[7:0], 3'b000} + {cold_ext[9:0], 1'b0});
      flags           <= {st_next.runaway,
                          |st_next.bits[cbsd_pkg::ST_FUSE_REAR:cbsd_pkg::ST_FUSE_AUX],
                          st_next.bits[cbsd_pkg::ST_INTERLOCK:cbsd_pkg::ST_PRECHARGE]};
      cell_voltage_mv <= (s1_cmd && s1_sel.hit) ? cell_sel_val : '0;
      frame_known     <= known;
    end
  end

  // nothing gets into the pipe before the store is cleared
  a_clear_empty: assert property (@(posedge clk)
    clearing |-> (!s1_valid && !out_valid))
    else $error("pipeline busy during cell store clearing");

  // frames never return a cell voltage
  a_frame_no_cell: assert property (@(posedge clk) disable iff (rst)
    (adv && !s1_cmd) |=> (cell_voltage_mv == '0))
    else $error("cell voltage on a frame result");

  // read requests never mark the battery alive
  a_read_not_known: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_cmd) |=> !frame_known)
    else $error("frame_known set on a cell read");

  // runaway flag stays once reported
  a_runaway_sticky: assert property (@(posedge clk) disable iff (rst)
    (adv && flags[4] && out_valid) |=> flags[4])
    else $error("runaway flag cleared without reset");

endmodule
